// File: rtl/core/sbl_pkg.sv
package sbl_pkg;

  localparam int MAX_BLOCKS = 4;
  localparam int SLOTS      = MAX_BLOCKS + 1;
  localparam int REPORTED   = 4;
  localparam int SEQ_W      = 32;
  localparam int COUNT_W    = 3;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int IDX_W      = $clog2(SLOTS);

  typedef logic [SEQ_W-1:0] seq_t;

  typedef struct packed {
    logic hit;
    seq_t lo;
    seq_t hi;
  } merge_t;

endpackage

// File: rtl/core/sbl_if.sv
interface sbl_in_if import sbl_pkg::*; ();
  logic valid;
  logic ready;
  seq_t block_start;
  seq_t block_end;

  modport source (output valid, output block_start, output block_end, input ready);
  modport sink (input valid, input block_start, input block_end, output ready);
endinterface

interface sbl_out_if import sbl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] entry_count;
  seq_t               first_start;
  seq_t               first_end;
  seq_t               second_start;
  seq_t               second_end;
  seq_t               third_start;
  seq_t               third_end;
  seq_t               fourth_start;
  seq_t               fourth_end;

  modport source (
    output valid, output entry_count,
    output first_start, output first_end, output second_start, output second_end,
    output third_start, output third_end, output fourth_start, output fourth_end,
    input ready
  );
  modport sink (
    input valid, input entry_count,
    input first_start, input first_end, input second_start, input second_end,
    input third_start, input third_end, input fourth_start, input fourth_end,
    output ready
  );
endinterface

// File: rtl/core/sack_block_list_update.sv
// the result is registered when the scan ends, the scan taking c compare steps
// (0 to 10, one per cycle through the single match unit, restarting on merge)
// input ready only while idle, so a new word is not taken until the scan of the last one has finished
// a finished result waiting in the output register stalls the end of the next scan
// reset: synchronous, active high; clears the list count, the sequencer and output valid
// stored block values are not reset and are only read below the count
module sack_block_list_update import sbl_pkg::*; (
  input logic   clk,
  input logic   rst,
  sbl_in_if.sink    blk,
  sbl_out_if.source res
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] i;
  seq_t ws [SLOTS];
  seq_t we [SLOTS];
  seq_t out_s [REPORTED];
  seq_t out_e [REPORTED];
  logic [COUNT_W-1:0] out_cnt;
  logic out_valid;

  merge_t merge;
  logic [CNT_W-1:0] n_fin;
  logic scan_more;
  logic finish;

  sbl_match u_match (
    .front_lo (ws[0]),
    .front_hi (we[0]),
    .cand_lo  (ws[i[IDX_W-1:0]]),
    .cand_hi  (we[i[IDX_W-1:0]]),
    .merge    (merge)
  );

  assign scan_more = (i < n);
  assign finish    = (state == ST_SCAN) && !scan_more && (!out_valid || res.ready);
  assign n_fin     = (n > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : n;

  assign blk.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      n         <= '0;
      i         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res.ready && !finish) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (blk.valid) begin
            n     <= n + CNT_W'(1);
            i     <= CNT_W'(1);
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_more) begin
            if (merge.hit) begin
              n <= n - CNT_W'(1);
              i <= CNT_W'(1);
            end else begin
              i <= i + CNT_W'(1);
            end
          end else if (finish) begin
            n         <= n_fin;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && blk.valid) begin
      ws[0] <= blk.block_start;
      we[0] <= blk.block_end;
      for (int k = 1; k < SLOTS; k++) begin
        ws[k] <= ws[k-1];
        we[k] <= we[k-1];
      end
    end else if (state == ST_SCAN && scan_more && merge.hit) begin
      ws[0] <= merge.lo;
      we[0] <= merge.hi;
      for (int k = 1; k < SLOTS - 1; k++) begin
        if (CNT_W'(k) >= i) begin
          ws[k] <= ws[k+1];
          we[k] <= we[k+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_cnt <= COUNT_W'(n_fin);
      for (int k = 0; k < REPORTED; k++) begin
        if (k < SLOTS && CNT_W'(k) < n_fin) begin
          out_s[k] <= ws[IDX_W'(k)];
          out_e[k] <= we[IDX_W'(k)];
        end else begin
          out_s[k] <= '0;
          out_e[k] <= '0;
        end
      end
    end
  end

  assign res.valid        = out_valid;
  assign res.entry_count  = out_cnt;
  assign res.first_start  = out_s[0];
  assign res.first_end    = out_e[0];
  assign res.second_start = out_s[1];
  assign res.second_end   = out_e[1];
  assign res.third_start  = out_s[2];
  assign res.third_end    = out_e[2];
  assign res.fourth_start = out_s[3];
  assign res.fourth_end   = out_e[3];

endmodule

// File: rtl/core/sbl_match.sv
module sbl_match import sbl_pkg::*; (
  input  seq_t   front_lo,
  input  seq_t   front_hi,
  input  seq_t   cand_lo,
  input  seq_t   cand_hi,
  output merge_t merge
);

  always_comb begin
    merge.hit = 1'b0;
    merge.lo  = front_lo;
    merge.hi  = front_hi;
    if (front_lo == cand_hi) begin
      merge.hit = 1'b1;
      merge.lo  = cand_lo;
    end else if (front_hi == cand_lo) begin
      merge.hit = 1'b1;
      merge.hi  = cand_hi;
    end
  end

endmodule

// File: rtl/core/sbl_checker.sv
module sbl_checker import sbl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] entry_count,
  input seq_t               fourth_start,
  input seq_t               fourth_end
);

  // input not ready in the cycle after a word is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_count))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count != '0 && entry_count <= COUNT_W'(REPORTED))
    else $error("entry count out of range");

  // unused slot reads as zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_count < COUNT_W'(REPORTED) |-> fourth_start == '0 && fourth_end == '0)
    else $error("unused slot not zero");

endmodule

bind sack_block_list_update sbl_checker u_sbl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (blk.valid),
  .in_ready     (blk.ready),
  .out_valid    (res.valid),
  .out_ready    (res.ready),
  .entry_count  (res.entry_count),
  .fourth_start (res.fourth_start),
  .fourth_end   (res.fourth_end)
);
